@@ rtl/stereo_shelf_biquad_cascade_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stereo shelf biquad cascade
// Concurrent checks clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_SHELF_BIQUAD_CASCADE_UNIT_ASSERT_SVH
`define STEREO_SHELF_BIQUAD_CASCADE_UNIT_ASSERT_SVH

`ifndef SYNTH

// condition holds at every edge
`define SSCB_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sscb check failed");

// antecedent implies consequent in the same cycle
`define SSCB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sscb check failed");

// antecedent implies consequent in the cycle after
`define SSCB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sscb check failed");

`else

`define SSCB_ASSERT_ALWAYS(lbl, cond)
`define SSCB_ASSERT_IMPL(lbl, ante, cons)
`define SSCB_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/sscb_pkg.sv @@
// ----------------------------------------------------------------------------
// sscb_pkg
// Shared types and constants of the stereo shelf biquad cascade.
// ----------------------------------------------------------------------------
`default_nettype none

package sscb_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEFF_BITS_DEF  = 20;
    localparam int COEFF_INT_BITS  = 6;     // Q5.14: sign + 5 integer bits

    // configuration register map
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 60;
    localparam int FWD_BITS       = 60;
    localparam int FB_BITS        = 40;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HS_FWD  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HS_FB   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LS_FWD  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LS_FB   = 3'd4;

    // state rows: one per (section, channel), {y2, y1, x2, x1}
    localparam int STATE_ROWS = 4;
    localparam int UNIT_BITS  = 2;

    // MAC tap sequence
    localparam int TAP_BITS  = 3;
    localparam int TAP_COUNT = 5;
    localparam logic [TAP_BITS-1:0] TAP_B0 = 3'd0;
    localparam logic [TAP_BITS-1:0] TAP_B1 = 3'd1;
    localparam logic [TAP_BITS-1:0] TAP_B2 = 3'd2;
    localparam logic [TAP_BITS-1:0] TAP_A1 = 3'd3;
    localparam logic [TAP_BITS-1:0] TAP_A2 = 3'd4;
    localparam logic [TAP_BITS-1:0] TAP_LAST_STEP = 3'd5;   // drain of last product

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_WRITE,
        ST_OUT
    } sscb_state_t;

    typedef struct packed {
        logic                 load_in;
        logic                 mem_rd;
        logic                 mem_wr;
        logic                 acc_init;
        logic                 mul_en;
        logic                 acc_en;
        logic [TAP_BITS-1:0]  tap;
        logic [UNIT_BITS-1:0] unit;
        logic                 load_out;
    } sscb_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/sscb_state_mem.sv @@
// ----------------------------------------------------------------------------
// sscb_state_mem
// Filter history memory, one row per section and channel, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sscb_state_mem
    import sscb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire sscb_ctrl_t               ctrl,
    input  wire logic [4*SAMPLE_BITS-1:0] wr_data,
    output logic      [4*SAMPLE_BITS-1:0] rd_data
);

    logic [4*SAMPLE_BITS-1:0] mem [STATE_ROWS];
    logic [4*SAMPLE_BITS-1:0] rd_data_reg;
    logic [STATE_ROWS-1:0]    valid_reg;
    logic                     rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.mem_wr)
        begin
            mem[ctrl.unit] <= wr_data;
        end
        if (ctrl.mem_rd)
        begin
            rd_data_reg <= mem[ctrl.unit];
        end
    end

    // rows never written read as zero history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.mem_wr)
            begin
                valid_reg[ctrl.unit] <= 1'b1;
            end
            if (ctrl.mem_rd)
            begin
                rd_valid_reg <= valid_reg[ctrl.unit];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

@@ rtl/sscb_mac.sv @@
// ----------------------------------------------------------------------------
// sscb_mac
// Shared multiply-accumulate with round-half-up and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module sscb_mac
    import sscb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = COEFF_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire sscb_ctrl_t                 ctrl,
    input  wire logic [SAMPLE_BITS-1:0]     x,
    input  wire logic [4*SAMPLE_BITS-1:0]   row,
    input  wire logic [3*COEFF_BITS-1:0]    fwd_coeffs,
    input  wire logic [2*COEFF_BITS-1:0]    fb_coeffs,
    output logic      [SAMPLE_BITS-1:0]     y
);

    localparam int FRAC_BITS = COEFF_BITS - COEFF_INT_BITS;
    localparam int PROD_BITS = COEFF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS  = PROD_BITS + 3;

    localparam logic signed [ACC_BITS-1:0] ROUND_INIT =
        ACC_BITS'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_BITS-1:0] SAT_LO =
        ACC_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    logic signed [COEFF_BITS-1:0]  coef;
    logic signed [SAMPLE_BITS-1:0] opnd;
    logic                          neg;
    logic signed [PROD_BITS-1:0]   prod;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic                          neg_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [ACC_BITS-1:0]    prod_ext;
    logic signed [ACC_BITS-1:0]    shifted;

    always_comb
    begin
        coef = fwd_coeffs[COEFF_BITS-1:0];
        opnd = x;
        neg  = 1'b0;
        case (ctrl.tap)
            TAP_B0:
            begin
                coef = fwd_coeffs[COEFF_BITS-1:0];
                opnd = x;
            end
            TAP_B1:
            begin
                coef = fwd_coeffs[2*COEFF_BITS-1:COEFF_BITS];
                opnd = row[SAMPLE_BITS-1:0];
            end
            TAP_B2:
            begin
                coef = fwd_coeffs[3*COEFF_BITS-1:2*COEFF_BITS];
                opnd = row[2*SAMPLE_BITS-1:SAMPLE_BITS];
            end
            TAP_A1:
            begin
                coef = fb_coeffs[COEFF_BITS-1:0];
                opnd = row[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
                neg  = 1'b1;
            end
            TAP_A2:
            begin
                coef = fb_coeffs[2*COEFF_BITS-1:COEFF_BITS];
                opnd = row[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
                neg  = 1'b1;
            end
            default:
            begin
                coef = '0;
                opnd = '0;
                neg  = 1'b0;
            end
        endcase
    end

    assign prod     = PROD_BITS'(coef) * PROD_BITS'(opnd);
    assign prod_ext = ACC_BITS'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod;
            neg_reg  <= neg;
        end
        if (ctrl.acc_init)
        begin
            acc_reg <= ROUND_INIT;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= neg_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
        end
    end

    // floor shift, then clamp to the sample range
    assign shifted = acc_reg >>> FRAC_BITS;

    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            y = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            y = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            y = shifted[SAMPLE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/sscb_ctrl.sv @@
// ----------------------------------------------------------------------------
// sscb_ctrl
// Sequencer: read row, five MAC taps, write back for four units, or bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module sscb_ctrl
    import sscb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic enable,
    input  wire logic out_free,
    output logic       busy,
    output sscb_ctrl_t ctrl
);

    sscb_state_t          state_reg, state_next;
    logic [UNIT_BITS-1:0] unit_reg, unit_next;
    logic [TAP_BITS-1:0]  step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            unit_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unit_reg  <= unit_next;
            step_reg  <= step_next;
        end
    end

    // input stall straight from state, kept apart from the start-driven strobes
    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unit_next  = unit_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unit_next  = '0;
                    state_next = enable ? ST_READ : ST_OUT;
                end
            end
            ST_READ:
            begin
                step_next  = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == TAP_LAST_STEP)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                unit_next = unit_reg + 1'b1;
                if (unit_reg == UNIT_BITS'(STATE_ROWS - 1))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.unit     = unit_reg;
        ctrl.tap      = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.load_in = start;
            end
            ST_READ:
            begin
                ctrl.mem_rd   = 1'b1;
                ctrl.acc_init = 1'b1;
            end
            ST_MAC:
            begin
                ctrl.mul_en = (step_reg < TAP_LAST_STEP);
                ctrl.acc_en = (step_reg != TAP_B0);
            end
            ST_WRITE:
            begin
                ctrl.mem_wr = 1'b1;
            end
            ST_OUT:
            begin
                ctrl.load_out = out_free;
            end
            default:
            begin
                ctrl.load_out = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/stereo_shelf_biquad_cascade_unit.sv @@
// ----------------------------------------------------------------------------
// stereo_shelf_biquad_cascade_unit
// Stereo high-shelf then low-shelf biquad cascade, direct form I, one MAC.
// ----------------------------------------------------------------------------
// Each accepted beat carries a left and a right sample. With enable set, each
// channel runs through the high-shelf biquad and then the low-shelf biquad:
// y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, coefficients signed Q5.14
// (COEFF_BITS wide), rounded half up and saturated to SAMPLE_BITS after every
// section. Both channels share a section's coefficients; history is kept per
// section and channel in a four-row state memory. A filtered beat makes four
// section/channel passes between the accept and the result load, each of one
// memory read, five products through the single shared multiplier plus a
// drain step, and one write back. With enable clear, a beat passes straight
// to the result load and the history is untouched. No new beat is accepted
// until the result is loaded. The finished result sits in an output register,
// so the next beat is accepted while it waits. Configuration writes are always
// accepted (cfg_ready is tied high) and must be issued only while the unit is
// idle; indices beyond the register map are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_shelf_biquad_cascade_unit_assert.svh"

module stereo_shelf_biquad_cascade_unit
    import sscb_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = COEFF_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    // sample channel
    input  wire logic                      sample_valid,
    output logic                           sample_stall,
    input  wire logic [SAMPLE_BITS-1:0]    left_sample,
    input  wire logic [SAMPLE_BITS-1:0]    right_sample,

    // result channel
    output logic                           result_valid,
    input  wire logic                      result_stall,
    output logic      [SAMPLE_BITS-1:0]    left_result,
    output logic      [SAMPLE_BITS-1:0]    right_result,

    // configuration write channel
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int FRAC_BITS = COEFF_BITS - COEFF_INT_BITS;
    localparam logic [FWD_BITS-1:0] FWD_RESET = FWD_BITS'(64'd1 << FRAC_BITS);

    // configuration registers
    logic                enable_reg;
    logic [FWD_BITS-1:0] hs_fwd_reg;
    logic [FB_BITS-1:0]  hs_fb_reg;
    logic [FWD_BITS-1:0] ls_fwd_reg;
    logic [FB_BITS-1:0]  ls_fb_reg;

    // working samples per channel; hold the running value between sections
    logic [SAMPLE_BITS-1:0] left_reg;
    logic [SAMPLE_BITS-1:0] right_reg;

    // output stage
    logic                   result_valid_reg;
    logic [SAMPLE_BITS-1:0] left_result_reg;
    logic [SAMPLE_BITS-1:0] right_result_reg;

    sscb_ctrl_t               ctrl;
    logic                     busy;
    logic                     sample_accept;
    logic                     out_free;
    logic [SAMPLE_BITS-1:0]   cur_x;
    logic [SAMPLE_BITS-1:0]   y;
    logic [4*SAMPLE_BITS-1:0] row_rd;
    logic [4*SAMPLE_BITS-1:0] row_wr;
    logic [FWD_BITS-1:0]      sec_fwd;
    logic [FB_BITS-1:0]       sec_fb;
    logic [3*COEFF_BITS-1:0]  fwd_coeffs;
    logic [2*COEFF_BITS-1:0]  fb_coeffs;

    assign cfg_ready     = 1'b1;
    assign sample_stall  = busy;
    assign sample_accept = sample_valid && !sample_stall;
    assign out_free      = !result_valid_reg || !result_stall;

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            hs_fwd_reg <= FWD_RESET;
            hs_fb_reg  <= '0;
            ls_fwd_reg <= FWD_RESET;
            ls_fb_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_HS_FWD: hs_fwd_reg <= cfg_data[FWD_BITS-1:0];
                REG_HS_FB:  hs_fb_reg  <= cfg_data[FB_BITS-1:0];
                REG_LS_FWD: ls_fwd_reg <= cfg_data[FWD_BITS-1:0];
                REG_LS_FB:  ls_fb_reg  <= cfg_data[FB_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // unit[1] picks the section, unit[0] the channel
    assign sec_fwd    = ctrl.unit[1] ? ls_fwd_reg : hs_fwd_reg;
    assign sec_fb     = ctrl.unit[1] ? ls_fb_reg  : hs_fb_reg;
    // coefficient fields past the register width read as zero
    assign fwd_coeffs = (3*COEFF_BITS)'(sec_fwd);
    assign fb_coeffs  = (2*COEFF_BITS)'(sec_fb);
    assign cur_x      = ctrl.unit[0] ? right_reg : left_reg;

    // ---- sequencer, history memory, MAC ----
    sscb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sample_accept),
        .enable   (enable_reg),
        .out_free (out_free),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    // history shift: x2 <= x1, x1 <= x, y2 <= y1, y1 <= y
    assign row_wr = {row_rd[3*SAMPLE_BITS-1:2*SAMPLE_BITS], y,
                     row_rd[SAMPLE_BITS-1:0], cur_x};

    sscb_state_mem #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .wr_data (row_wr),
        .rd_data (row_rd)
    );

    sscb_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_mac (
        .clk        (clk),
        .ctrl       (ctrl),
        .x          (cur_x),
        .row        (row_rd),
        .fwd_coeffs (fwd_coeffs),
        .fb_coeffs  (fb_coeffs),
        .y          (y)
    );

    // ---- working samples ----
    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            left_reg  <= left_sample;
            right_reg <= right_sample;
        end
        else if (ctrl.mem_wr)
        begin
            // section output feeds the next section of the same channel
            if (ctrl.unit[0])
            begin
                right_reg <= y;
            end
            else
            begin
                left_reg <= y;
            end
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            left_result_reg  <= left_reg;
            right_result_reg <= right_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign left_result  = left_result_reg;
    assign right_result = right_result_reg;

    // ---- checks ----
    // one beat in flight: an accepted beat keeps the input stalled next cycle
    `SSCB_ASSERT_NEXT(a_one_in_flight, sample_accept, sample_stall)
    // a waiting result is never overwritten
    `SSCB_ASSERT_IMPL(a_no_overwrite, ctrl.load_out, !result_valid_reg || !result_stall)
    // history read and write back never collide
    `SSCB_ASSERT_ALWAYS(a_mem_excl, !(ctrl.mem_rd && ctrl.mem_wr))
    // write back always follows the MAC drain step
    `SSCB_ASSERT_NEXT(a_wr_after_drain, ctrl.acc_en && !ctrl.mul_en, ctrl.mem_wr)

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for stereo_shelf_biquad_cascade_unit
// Drives stereo sample beats and register writes and checks every result beat
// against an in-bench model of the two DF-I shelf sections or a pinned value.
// The model keeps its own coefficient copy and per-channel history.
// ----------------------------------------------------------------------------
module tb_top;
    import sscb_pkg::*;

    localparam int     SW         = SAMPLE_BITS_DEF;
    localparam int     CB         = COEFF_BITS_DEF;
    localparam int     FRAC       = CB - COEFF_INT_BITS;
    localparam longint ROUND_HALF = longint'(1) << (FRAC - 1);
    localparam longint S_HI       = (longint'(1) << (SW - 1)) - 1;
    localparam longint S_LO       = -S_HI - 1;

    typedef logic [SW-1:0]             sample_t;
    typedef logic [CFG_INDEX_BITS-1:0] reg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  reg_word_t;

    localparam sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};

    // indexes past the register map; writes there must be dropped
    localparam reg_index_t REG_SPARE_LO  = 3'd5;
    localparam reg_index_t REG_SPARE_MID = 3'd6;
    localparam reg_index_t REG_SPARE_HI  = 3'd7;

    localparam reg_word_t UNITY_FWD = reg_word_t'(longint'(1) << FRAC);
    localparam reg_word_t ALL_ONES  = {CFG_DATA_BITS{1'b1}};
    localparam reg_word_t ALL_ZEROS = '0;

    localparam int BEATS_PER_PHASE = 106;
    localparam int PHASES          = 8;
    localparam int PLAN_ROWS       = 25;

    typedef struct {
        sample_t left;
        sample_t right;
    } pair_t;

    typedef enum logic {STEP_CFG, STEP_BEAT} step_kind_t;

    // One row of the directed plan. For beats, pin marks a row whose result
    // is written out by hand instead of taken from the model.
    typedef struct {
        step_kind_t kind;
        reg_index_t idx;
        reg_word_t  data;
        sample_t    l;
        sample_t    r;
        bit         pin;
        sample_t    el;
        sample_t    er;
    } plan_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT-facing signals. Every input has a known value at 0.
    // ------------------------------------------------------------------------
    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       sample_valid = 1'b0;
    sample_t    left_sample  = '0;
    sample_t    right_sample = '0;
    logic       result_stall = 1'b0;
    logic       cfg_valid    = 1'b0;
    reg_index_t cfg_index    = '0;
    reg_word_t  cfg_data     = '0;

    logic       sample_stall;
    logic       result_valid;
    sample_t    left_result;
    sample_t    right_result;
    logic       cfg_ready;

    always #5 clk = ~clk;

    stereo_shelf_biquad_cascade_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .left_result  (left_result),
        .right_result (right_result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Model state: register copy (reset values) and DF-I history.
    // History entry = section*4 + channel*2 + age, age 0 newest.
    // ------------------------------------------------------------------------
    logic                    mirror_enable = 1'b1;
    logic [FWD_BITS-1:0]     hs_fwd        = UNITY_FWD[FWD_BITS-1:0];
    logic [FB_BITS-1:0]      hs_fb         = '0;
    logic [FWD_BITS-1:0]     ls_fwd        = UNITY_FWD[FWD_BITS-1:0];
    logic [FB_BITS-1:0]      ls_fb         = '0;
    longint                  hist_x [8]    = '{default: 0};
    longint                  hist_y [8]    = '{default: 0};

    pair_t   filtered_pairs_due [$];

    // hand-written expectation riding along with the current sample beat
    logic    pinned_valid = 1'b0;
    sample_t pinned_left  = '0;
    sample_t pinned_right = '0;

    int idle_pct  = 0;      // sender idle chance per cycle, percent
    int stall_pct = 0;      // receiver stall chance per cycle, percent

    int fail_count      = 0;
    int accepted_beats  = 0;
    int results_checked = 0;
    int reg_writes      = 0;

    // ------------------------------------------------------------------------
    // One biquad section, direct form I. Products are at most 44 bits and the
    // five-term sum stays well inside 64 bits. >>> on a signed longint is a
    // floor shift, so adding half an LSB first gives round-half-up. The
    // saturated value is what goes back into the output history.
    // ------------------------------------------------------------------------
    function automatic longint biquad_section(input longint x,
                                              input logic [FWD_BITS-1:0] fwd,
                                              input logic [FB_BITS-1:0] fb,
                                              input int base);
        longint b0, b1, b2, a1, a2, acc, y;
        b0  = longint'($signed(fwd[CB-1:0]));
        b1  = longint'($signed(fwd[2*CB-1:CB]));
        b2  = longint'($signed(fwd[3*CB-1:2*CB]));
        a1  = longint'($signed(fb[CB-1:0]));
        a2  = longint'($signed(fb[2*CB-1:CB]));
        acc = b0 * x + b1 * hist_x[base] + b2 * hist_x[base+1]
            - a1 * hist_y[base] - a2 * hist_y[base+1];
        y   = (acc + ROUND_HALF) >>> FRAC;
        if (y > S_HI)
            y = S_HI;
        else if (y < S_LO)
            y = S_LO;
        hist_x[base+1] = hist_x[base];
        hist_x[base]   = x;
        hist_y[base+1] = hist_y[base];
        hist_y[base]   = y;
        return y;
    endfunction

    // Full stereo path: high shelf then low shelf per channel, or bypass.
    function automatic pair_t shelve_pair(input sample_t l, input sample_t r);
        longint xl, xr;
        pair_t  p;
        xl = longint'($signed(l));
        xr = longint'($signed(r));
        if (mirror_enable)
        begin
            xl = biquad_section(xl, hs_fwd, hs_fb, 0);
            xr = biquad_section(xr, hs_fwd, hs_fb, 2);
            xl = biquad_section(xl, ls_fwd, ls_fb, 4);
            xr = biquad_section(xr, ls_fwd, ls_fb, 6);
        end
        p.left  = xl[SW-1:0];
        p.right = xr[SW-1:0];
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard. Both handshakes are sampled at the edge with pre-edge values
    // (all bench drives are nonblocking), so order within the step is moot.
    // Even the pass-through path goes through the output state and the output
    // register, so a push never has to meet a pop for the same beat at one edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        pair_t want;
        if (rst_n && sample_valid && !sample_stall)
        begin
            want = shelve_pair(left_sample, right_sample);
            if (pinned_valid)
            begin
                want.left  = pinned_left;
                want.right = pinned_right;
            end
            filtered_pairs_due.push_back(want);
            accepted_beats++;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (filtered_pairs_due.size() == 0)
            begin
                $error("unexpected result beat: left_result %0d right_result %0d",
                       $signed(left_result), $signed(right_result));
                fail_count++;
            end
            else
            begin
                want = filtered_pairs_due.pop_front();
                results_checked++;
                if (left_result !== want.left)
                begin
                    $error("left_result: expected %0d, actual %0d",
                           $signed(want.left), $signed(left_result));
                    fail_count++;
                end
                if (right_result !== want.right)
                begin
                    $error("right_result: expected %0d, actual %0d",
                           $signed(want.right), $signed(right_result));
                    fail_count++;
                end
            end
        end
    end

    // receiver back-pressure, re-rolled every cycle
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one sample beat and hold it until taken. valid is left high on
    // return so back-to-back beats never drop it within a step.
    task automatic send_pair(input sample_t l, input sample_t r,
                             input bit pin, input sample_t el, input sample_t er);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        left_sample  <= l;
        right_sample <= r;
        pinned_valid <= pin;
        pinned_left  <= el;
        pinned_right <= er;
        do
            @(posedge clk);
        while (sample_stall);
    endtask

    // Stop sending and wait for every expected result. Each beat yields one
    // result, so an empty queue means the unit is idle.
    task automatic drain_results();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (filtered_pairs_due.size() != 0)
            @(posedge clk);
    endtask

    // Register write, only ever issued with the datapath idle.
    task automatic write_reg(input reg_index_t idx, input reg_word_t data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        // bits above each register's width are dropped, unmapped indexes too
        case (idx)
            REG_ENABLE: mirror_enable = data[0];
            REG_HS_FWD: hs_fwd        = data[FWD_BITS-1:0];
            REG_HS_FB:  hs_fb         = data[FB_BITS-1:0];
            REG_LS_FWD: ls_fwd        = data[FWD_BITS-1:0];
            REG_LS_FB:  ls_fb         = data[FB_BITS-1:0];
            default:    ;
        endcase
    endtask

    function automatic reg_word_t wide_rand();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[CFG_DATA_BITS-1:0];
    endfunction

    // Audio-like shelf: b0 0.5..2.0, b1/b2 within +-1.0/+-0.5.
    function automatic reg_word_t gentle_forward();
        int b0, b1, b2;
        b0 = int'($urandom_range(8192, 32768));
        b1 = int'($urandom_range(0, 32768)) - 16384;
        b2 = int'($urandom_range(0, 16384)) - 8192;
        return {b2[CB-1:0], b1[CB-1:0], b0[CB-1:0]};
    endfunction

    // a1 within +-1.5, a2 within +-0.7; junk in the unused top bits
    function automatic reg_word_t gentle_feedback();
        int a1, a2;
        a1 = int'($urandom_range(0, 49152)) - 24576;
        a2 = int'($urandom_range(0, 22936)) - 11468;
        return {20'($urandom), a2[CB-1:0], a1[CB-1:0]};
    endfunction

    // Mostly full-range samples, with rails and small signals mixed in.
    function automatic sample_t rand_sample();
        int v;
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2, 3, 4:
            begin
                v = int'($urandom_range(0, 8192)) - 4096;
                return v[SW-1:0];
            end
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Load one coefficient setting; all five registers every phase.
    task automatic program_phase(input int ph);
        reg_word_t junk;
        junk = wide_rand();
        write_reg(REG_ENABLE, {junk[CFG_DATA_BITS-1:1], (ph % PHASES) != 3});
        case (ph % PHASES)
            0:
            begin
                write_reg(REG_HS_FWD, UNITY_FWD);
                write_reg(REG_HS_FB,  ALL_ZEROS);
                write_reg(REG_LS_FWD, UNITY_FWD);
                write_reg(REG_LS_FB,  ALL_ZEROS);
            end
            1, 7:
            begin
                write_reg(REG_HS_FWD, gentle_forward());
                write_reg(REG_HS_FB,  gentle_feedback());
                write_reg(REG_LS_FWD, gentle_forward());
                write_reg(REG_LS_FB,  gentle_feedback());
            end
            4:
            begin
                write_reg(REG_HS_FWD, ALL_ONES);
                write_reg(REG_HS_FB,  ALL_ONES);
                write_reg(REG_LS_FWD, ALL_ONES);
                write_reg(REG_LS_FB,  ALL_ONES);
            end
            5:
            begin
                write_reg(REG_HS_FWD, ALL_ZEROS);
                write_reg(REG_HS_FB,  ALL_ZEROS);
                write_reg(REG_LS_FWD, ALL_ZEROS);
                write_reg(REG_LS_FB,  ALL_ZEROS);
            end
            6:
            begin
                // coefficient rails: +31.99 / -32.0 in every slot
                write_reg(REG_HS_FWD, 60'h80000_80000_7FFFF);
                write_reg(REG_HS_FB,  60'h00000_7FFFF_80000);
                write_reg(REG_LS_FWD, 60'h7FFFF_80000_80000);
                write_reg(REG_LS_FB,  60'hFFFFF_80000_7FFFF);
            end
            default:
            begin
                // raw random words; phase 3 lands here with bypass on
                write_reg(REG_HS_FWD, wide_rand());
                write_reg(REG_HS_FB,  wide_rand());
                write_reg(REG_LS_FWD, wide_rand());
                write_reg(REG_LS_FB,  wide_rand());
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        plan_row_t plan [PLAN_ROWS];
        int        ph;
        int        n;

        // After reset both sections are unity with no feedback, so a beat
        // comes straight back. Bypass rows echo the input. The rail rows use
        // b0 at +31.99 or -32.0 with nothing else active, so they pin to the
        // rails. The last rows run real filtering against the model.
        plan = '{
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, 24'h000000, 24'h000000,
              1'b1, 24'h000000, 24'h000000},
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, S_MAX, S_MIN, 1'b1, S_MAX, S_MIN},
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, S_MIN, S_MAX, 1'b1, S_MIN, S_MAX},
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, 24'h000001, 24'hFFFFFF,
              1'b1, 24'h000001, 24'hFFFFFF},
            // bypass, with junk above bit 0
            '{STEP_CFG,  REG_ENABLE,    60'hFFF_FFFF_FFFF_FFFE, '0, '0, 1'b0, '0, '0},
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, 24'h123456, 24'h9ABCDF,
              1'b1, 24'h123456, 24'h9ABCDF},
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, S_MAX, S_MIN, 1'b1, S_MAX, S_MIN},
            // unmapped indexes must not disturb anything
            '{STEP_CFG,  REG_SPARE_LO,  ALL_ONES, '0, '0, 1'b0, '0, '0},
            '{STEP_CFG,  REG_SPARE_MID, ALL_ONES, '0, '0, 1'b0, '0, '0},
            '{STEP_CFG,  REG_SPARE_HI,  ALL_ONES, '0, '0, 1'b0, '0, '0},
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, 24'h000005, 24'hFFFFFB,
              1'b1, 24'h000005, 24'hFFFFFB},
            '{STEP_CFG,  REG_ENABLE,    ALL_ONES, '0, '0, 1'b0, '0, '0},
            // high-shelf b0 at +31.99: both rails saturate
            '{STEP_CFG,  REG_HS_FWD,    60'h00000_00000_7FFFF, '0, '0, 1'b0, '0, '0},
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, S_MAX, S_MIN, 1'b1, S_MAX, S_MIN},
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, S_MIN, S_MAX, 1'b1, S_MIN, S_MAX},
            // b0 at -32.0: rails swap
            '{STEP_CFG,  REG_HS_FWD,    60'h00000_00000_80000, '0, '0, 1'b0, '0, '0},
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, S_MAX, S_MIN, 1'b1, S_MIN, S_MAX},
            '{STEP_CFG,  REG_HS_FB,     ALL_ONES, '0, '0, 1'b0, '0, '0},
            '{STEP_CFG,  REG_LS_FWD,    60'hFE000_02000_04000, '0, '0, 1'b0, '0, '0},
            '{STEP_CFG,  REG_LS_FB,     60'hABCDE_01000_F8000, '0, '0, 1'b0, '0, '0},
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, 24'h0003E8, 24'hFFFC18,
              1'b0, '0, '0},
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, 24'h000000, 24'h000000,
              1'b0, '0, '0},
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, S_MAX, S_MAX, 1'b0, '0, '0},
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, S_MIN, S_MIN, 1'b0, '0, '0},
            '{STEP_BEAT, REG_ENABLE,    ALL_ZEROS, 24'h000007, 24'h000003,
              1'b0, '0, '0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling
        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_CFG)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_pair(plan[i].l, plan[i].r, plan[i].pin, plan[i].el, plan[i].er);
        end

        // random part: each coefficient setting is paired with one of four
        // idle patterns, so every pattern is used by two of the phases
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            program_phase(ph);
            for (n = 0; n < BEATS_PER_PHASE; n++)
                send_pair(rand_sample(), rand_sample(), 1'b0, '0, '0);
        end

        // wait out the queue, then a filtered beat's worth of cycles to catch
        // any stray result
        drain_results();
        repeat (40) @(posedge clk);

        $display("Covered %0d sample beats and %0d register writes over %0d settings",
                 accepted_beats, reg_writes, PHASES + 1);
        $display("(bypass, rails, unstable and audio-like shelves); %0d results compared",
                 results_checked);
        if (fail_count == 0)
            $display("[stereo_shelf_biquad_cascade_unit] OK");
        else
            $display("[stereo_shelf_biquad_cascade_unit] ERROR");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #(5_000_000);
        $display("[stereo_shelf_biquad_cascade_unit] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sscb_pkg.sv
rtl/sscb_state_mem.sv
rtl/sscb_mac.sv
rtl/sscb_ctrl.sv
rtl/stereo_shelf_biquad_cascade_unit.sv
dv/tb_top.sv
